@@ src/tstt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tstt_pkg
// shared types, constants and tables of the timestamp text to ticks block
// ---------------------------------------------------------------------------
package tstt_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_DASH       = 8'h2d;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

    localparam logic [4:0] POS_YEAR_SEP   = 5'd4;
    localparam logic [4:0] POS_MONTH_SEP  = 5'd7;
    localparam logic [4:0] POS_DATE_SEP   = 5'd10;
    localparam logic [4:0] POS_HOUR_SEP   = 5'd13;
    localparam logic [4:0] POS_MINUTE_SEP = 5'd16;
    localparam logic [4:0] STAMP_LEN      = 5'd19;
    localparam logic [4:0] POS_SAT        = 5'd20;

    localparam logic [13:0] MAX_YEAR   = 14'd9999;
    localparam logic [6:0]  MAX_MONTH  = 7'd12;
    localparam logic [6:0]  MAX_HOUR   = 7'd23;
    localparam logic [6:0]  MAX_MINSEC = 7'd59;

    // floor(x / 100) = (x * 5243) >> 19 for x below 10000
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [23:0] TICKS_PER_SEC  = 24'd10000000;
    localparam int          SECS_LO_W      = 20;
    localparam logic [61:0] MAX_TICKS      = 62'd3155378975990000000;

    typedef struct packed {
        logic        text_ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } stamp_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_QYEAR,
        B_QPREV,
        B_CHECK,
        B_DAYS,
        B_SECS,
        B_MLO,
        B_MHI,
        B_OUT
    } back_state_t;

    // days of the year before the start of month m + 1
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            4'd12:   base = 9'd365;
            default: base = 9'd0;
        endcase
        return (leap && m >= 4'd2) ? base + 9'd1 : base;
    endfunction

endpackage

@@ src/tstt_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tstt_front
// takes text words, checks each character and gathers the date fields
// ---------------------------------------------------------------------------
module tstt_front import tstt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       push_valid,
    input  logic       push_ready,
    output stamp_t     push_data
);

    logic [4:0]  pos_reg, pos_next, pos_upd;
    logic        bad_reg, bad_next, bad_upd;
    logic [13:0] year_reg, year_next, year_upd;
    logic [6:0]  month_reg, month_next, month_upd;
    logic [6:0]  day_reg, day_next, day_upd;
    logic [6:0]  hour_reg, hour_next, hour_upd;
    logic [6:0]  minute_reg, minute_next, minute_upd;
    logic [6:0]  second_reg, second_next, second_upd;
    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;

    function automatic logic [13:0] acc_step(input logic [13:0] acc, input logic [3:0] d);
        return {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, d};
    endfunction

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit    = s_tdata[3:0];

    always_comb begin
        pos_upd    = pos_reg;
        bad_upd    = bad_reg;
        year_upd   = year_reg;
        month_upd  = month_reg;
        day_upd    = day_reg;
        hour_upd   = hour_reg;
        minute_upd = minute_reg;
        second_upd = second_reg;
        if (pos_reg < STAMP_LEN) begin
            case (pos_reg)
                POS_YEAR_SEP, POS_MONTH_SEP, POS_HOUR_SEP, POS_MINUTE_SEP: begin
                    if (s_tdata != CHAR_DASH) bad_upd = 1'b1;
                end
                POS_DATE_SEP: begin
                    if (s_tdata != CHAR_UNDERSCORE) bad_upd = 1'b1;
                end
                default: begin
                    if (!is_digit) begin
                        bad_upd = 1'b1;
                    end else if (pos_reg < POS_YEAR_SEP) begin
                        year_upd = acc_step(year_reg, digit);
                    end else if (pos_reg < POS_MONTH_SEP) begin
                        month_upd = 7'(acc_step({7'd0, month_reg}, digit));
                    end else if (pos_reg < POS_DATE_SEP) begin
                        day_upd = 7'(acc_step({7'd0, day_reg}, digit));
                    end else if (pos_reg < POS_HOUR_SEP) begin
                        hour_upd = 7'(acc_step({7'd0, hour_reg}, digit));
                    end else if (pos_reg < POS_MINUTE_SEP) begin
                        minute_upd = 7'(acc_step({7'd0, minute_reg}, digit));
                    end else begin
                        second_upd = 7'(acc_step({7'd0, second_reg}, digit));
                    end
                end
            endcase
        end
        if (pos_reg < POS_SAT) pos_upd = pos_reg + 5'd1;
    end

    always_comb begin
        pos_next    = pos_reg;
        bad_next    = bad_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (accept) begin
            if (s_tlast) begin
                pos_next    = '0;
                bad_next    = 1'b0;
                year_next   = '0;
                month_next  = '0;
                day_next    = '0;
                hour_next   = '0;
                minute_next = '0;
                second_next = '0;
            end else begin
                pos_next    = pos_upd;
                bad_next    = bad_upd;
                year_next   = year_upd;
                month_next  = month_upd;
                day_next    = day_upd;
                hour_next   = hour_upd;
                minute_next = minute_upd;
                second_next = second_upd;
            end
        end
    end

    assign push_valid        = accept && s_tlast;
    assign push_data.text_ok = (pos_upd == STAMP_LEN) && !bad_upd;
    assign push_data.year    = year_upd;
    assign push_data.month   = month_upd;
    assign push_data.day     = day_upd;
    assign push_data.hour    = hour_upd;
    assign push_data.minute  = minute_upd;
    assign push_data.second  = second_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            bad_reg    <= 1'b0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            bad_reg    <= bad_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

endmodule

@@ src/tstt_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tstt_fifo
// short queue of gathered timestamps between the front and back parts
// ---------------------------------------------------------------------------
module tstt_fifo import tstt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  stamp_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output stamp_t pop_data
);

    stamp_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/tstt_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tstt_back
// range checks and tick arithmetic of one timestamp, sequenced over cycles
// ---------------------------------------------------------------------------
module tstt_back import tstt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  stamp_t      pop_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata
);

    back_state_t  state_reg, state_next;
    stamp_t       stamp_reg, stamp_next;
    logic [6:0]   q_year_reg, q_year_next;
    logic [6:0]   q_prev_reg, q_prev_next;
    logic         leap_reg, leap_next;
    logic         ok_reg, ok_next;
    logic [21:0]  ylin_reg, ylin_next;
    logic [21:0]  days_reg, days_next;
    logic [16:0]  hms_reg, hms_next;
    logic [38:0]  secs_reg, secs_next;
    logic [43:0]  plo_reg, plo_next;
    logic [61:0]  tick_reg, tick_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_data_reg, out_data_next;

    logic [13:0]  year_prev;
    logic [26:0]  recip_prod;
    logic [3:0]   mon;
    logic         leap_c;
    logic [8:0]   mon_len;
    logic         range_ok;
    logic [42:0]  phi;
    logic         out_free;

    assign year_prev = stamp_reg.year - 14'd1;
    assign mon       = stamp_reg.month[3:0];
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        stamp_next     = stamp_reg;
        q_year_next    = q_year_reg;
        q_prev_next    = q_prev_reg;
        leap_next      = leap_reg;
        ok_next        = ok_reg;
        ylin_next      = ylin_reg;
        days_next      = days_reg;
        hms_next       = hms_reg;
        secs_next      = secs_reg;
        plo_next       = plo_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop_ready      = 1'b0;
        recip_prod     = '0;
        leap_c         = 1'b0;
        mon_len        = '0;
        range_ok       = 1'b0;
        phi            = '0;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        case (state_reg)
            B_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    stamp_next = pop_data;
                    state_next = B_QYEAR;
                end
            end
            B_QYEAR: begin
                recip_prod  = stamp_reg.year * RECIP_100;
                q_year_next = recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
                state_next  = B_QPREV;
            end
            B_QPREV: begin
                recip_prod  = year_prev * RECIP_100;
                q_prev_next = recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
                state_next  = B_CHECK;
            end
            B_CHECK: begin
                leap_c = (stamp_reg.year[1:0] == 2'b00)
                    && ((stamp_reg.year != 14'(q_year_reg * 7'd100))
                        || (q_year_reg[1:0] == 2'b00));
                mon_len  = month_start(mon, leap_c) - month_start(mon - 4'd1, leap_c);
                range_ok = (stamp_reg.year >= 14'd1) && (stamp_reg.year <= MAX_YEAR)
                    && (stamp_reg.month >= 7'd1) && (stamp_reg.month <= MAX_MONTH)
                    && (stamp_reg.hour <= MAX_HOUR) && (stamp_reg.minute <= MAX_MINSEC)
                    && (stamp_reg.second <= MAX_MINSEC);
                ok_next = stamp_reg.text_ok && range_ok && (stamp_reg.day >= 7'd1)
                    && ({2'b00, stamp_reg.day} <= mon_len);
                leap_next = leap_c;
                ylin_next = 22'(year_prev * DAYS_PER_YEAR) + {10'd0, year_prev[13:2]}
                    - {15'd0, q_prev_reg} + {17'd0, q_prev_reg[6:2]};
                state_next = B_DAYS;
            end
            B_DAYS: begin
                days_next = ylin_reg + {13'd0, month_start(mon - 4'd1, leap_reg)}
                    + {15'd0, stamp_reg.day} - 22'd1;
                hms_next = 17'(stamp_reg.hour * SECS_PER_HOUR)
                    + 17'(stamp_reg.minute * SECS_PER_MIN) + {10'd0, stamp_reg.second};
                state_next = B_SECS;
            end
            B_SECS: begin
                secs_next  = 39'(days_reg * SECS_PER_DAY) + {22'd0, hms_reg};
                state_next = B_MLO;
            end
            B_MLO: begin
                plo_next   = secs_reg[SECS_LO_W-1:0] * TICKS_PER_SEC;
                state_next = B_MHI;
            end
            B_MHI: begin
                phi        = secs_reg[38:SECS_LO_W] * TICKS_PER_SEC;
                tick_next  = 62'({phi, {SECS_LO_W{1'b0}}}) + {18'd0, plo_reg};
                state_next = B_OUT;
            end
            B_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, ok_reg ? tick_reg : 62'd0, ok_reg};
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        stamp_reg    <= stamp_next;
        q_year_reg   <= q_year_next;
        q_prev_reg   <= q_prev_next;
        leap_reg     <= leap_next;
        ok_reg       <= ok_next;
        ylin_reg     <= ylin_next;
        days_reg     <= days_next;
        hms_reg      <= hms_next;
        secs_reg     <= secs_next;
        plo_reg      <= plo_next;
        tick_reg     <= tick_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/timestamp_text_to_ticks.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timestamp_text_to_ticks
// parses 'yyyy-MM-dd_HH-mm-ss' text into 100 ns ticks since 0001-01-01
// ---------------------------------------------------------------------------
// One character is taken per word, one word per cycle, with tlast on the final
// character of a timestamp. Characters are checked and the date fields gathered
// as they arrive; on tlast the gathered fields go into a two-entry queue and the
// stream carries on. A back sequencer takes each queued timestamp through range
// checks and the tick arithmetic (two reciprocal divisions by 100, checks, day
// count, seconds, and a 39 by 24 bit product in two halves) and pops the next
// timestamp only once the last result is in the output register; the input
// only stalls when the queue is full. The result word gives ok in bit 0 and the
// tick count in bits 62:1, forced to zero when the text is not a valid time.
// ---------------------------------------------------------------------------
module timestamp_text_to_ticks import tstt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // ok[0], tick_count[62:1], zero[63]
);

    logic   push_valid, push_ready;
    stamp_t push_data;
    logic   pop_valid, pop_ready;
    stamp_t pop_data;

    tstt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tstt_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tstt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_not_ok_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[62:1] == 62'd0))
        else $error("tick count not zero on a failed timestamp");

    a_ticks_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[62:1] <= MAX_TICKS) && !m_tdata[63])
        else $error("tick count beyond the last valid time");

    a_final_queued : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> pop_valid)
        else $error("final character did not reach the queue");

endmodule
